[rtl/sda_pkg.sv]
// Shared definitions for the two-stacks-in-one-store block.
// Holds field widths, command and status codes, and the queued request type.
// No dependencies.
package sda_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int WORD_W_DEF    = 32;

    localparam int CMD_W         = 3;
    localparam int VAL_W         = 32;
    localparam int STAT_W        = 3;
    localparam int DATA_W        = 32;
    localparam int POS_W         = 4;
    localparam int CAP_W         = 5;
    localparam int OUT_TDATA_W   = 40;
    localparam int CAP_RST_DEF   = 16;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SEARCH     = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 3'd1;
    localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 3'd2;
    localparam logic [STAT_W-1:0] STAT_MATCH     = 3'd3;
    localparam logic [STAT_W-1:0] STAT_DONE      = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [VAL_W-1:0] value;
    } sda_req_t;

    typedef struct packed {
        logic valid;
        logic full;
    } sda_qstat_t;

endpackage

[rtl/sda_front.sv]
// Front end: accepts input requests and classifies commands.
// Drops unknown commands and forwards valid ones to the request queue.
// Depends on sda_pkg.
module sda_front import sda_pkg::*; (
    input  logic              aresetn,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [VAL_W-1:0]  s_axis_tdata,   // value[31:0]
    input  logic [CMD_W-1:0]  s_axis_tuser,   // command[2:0]
    input  logic              q_full,
    output logic              q_push,
    output sda_req_t          q_req
);

    logic known;

    always_comb begin
        case (s_axis_tuser)
            CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_POP_FRONT, CMD_POP_BACK, CMD_SEARCH: begin
                known = 1'b1;
            end
            default: begin
                known = 1'b0;
            end
        endcase
    end

    assign s_axis_tready = ~q_full & aresetn;
    assign q_push        = s_axis_tvalid & s_axis_tready & known;
    assign q_req.cmd     = s_axis_tuser;
    assign q_req.value   = s_axis_tdata;

endmodule

[rtl/sda_queue.sv]
// Two-entry request queue between the front end and the execution unit.
// Lets either side stall on its own.
// Depends on sda_pkg.
module sda_queue import sda_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  sda_req_t   push_req,
    input  logic       pop,
    output sda_req_t   pop_req,
    output sda_qstat_t stat
);

    sda_req_t   slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign stat.valid = (count_reg != 2'd0);
    assign stat.full  = (count_reg == 2'd2);
    assign do_push    = push & ~stat.full;
    assign do_pop     = pop & stat.valid;
    assign pop_req    = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

[rtl/sda_back.sv]
// Execution unit: entry store, stack counts, capacity register, search walk
// and the output register. Depends on sda_pkg.
module sda_back import sda_pkg::*; #(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int WORD_WIDTH = WORD_W_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  sda_qstat_t              q_stat,
    input  sda_req_t                q_req,
    output logic                    q_pop,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CAP_W-1:0]        cfg_data,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic [STAT_W-1:0]       m_axis_tuser,
    output logic                    m_axis_tlast
);

    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CAP_RST = (DEPTH < CAP_RST_DEF) ? DEPTH : CAP_RST_DEF;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_POP  = 5'b00010,
        S_SRD  = 5'b00100,
        S_SCMP = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       cap_reg, cap_next;
    logic [CNT_W-1:0]       front_reg, front_next;
    logic [CNT_W-1:0]       back_reg, back_next;
    logic [CNT_W-1:0]       rem_reg, rem_next;
    logic [IDX_W-1:0]       pos_reg, pos_next;
    logic                   side_reg, side_next;
    logic [WORD_WIDTH-1:0]  key_reg, key_next;

    logic [WORD_WIDTH-1:0]  mem [DEPTH];
    logic [WORD_WIDTH-1:0]  rd_data_reg;
    logic                   wr_en, rd_en;
    logic [IDX_W-1:0]       wr_addr, rd_addr;
    logic [WORD_WIDTH-1:0]  wr_data;

    logic                   m_valid_reg, m_valid_next;
    logic [STAT_W-1:0]      m_stat_reg, m_stat_next;
    logic [DATA_W-1:0]      m_data_reg, m_data_next;
    logic [POS_W-1:0]       m_pos_reg, m_pos_next;
    logic                   m_last_reg, m_last_next;

    logic                   out_free, full, hit, emit;
    logic [CNT_W:0]         used;
    logic [CNT_W-1:0]       back_inc;
    logic [STAT_W-1:0]      e_stat;
    logic [DATA_W-1:0]      e_data;
    logic [POS_W-1:0]       e_pos;
    logic                   e_last;

    assign cfg_ready     = 1'b1;
    assign out_free      = ~m_valid_reg | m_axis_tready;
    assign used          = {1'b0, front_reg} + {1'b0, back_reg};
    assign full          = (used >= {1'b0, cap_reg});
    assign back_inc      = back_reg + CNT_W'(1);
    assign hit           = (rd_data_reg == key_reg);

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - DATA_W - POS_W){1'b0}}, m_pos_reg, m_data_reg};
    assign m_axis_tuser  = m_stat_reg;
    assign m_axis_tlast  = m_last_reg;

    always_comb begin
        state_next = state_reg;
        cap_next   = cap_reg;
        front_next = front_reg;
        back_next  = back_reg;
        rem_next   = rem_reg;
        pos_next   = pos_reg;
        side_next  = side_reg;
        key_next   = key_reg;
        q_pop      = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = IDX_W'(front_reg);
        wr_data    = WORD_WIDTH'(q_req.value);
        rd_en      = 1'b0;
        rd_addr    = pos_reg;
        emit       = 1'b0;
        e_stat     = STAT_OK;
        e_data     = '0;
        e_pos      = '0;
        e_last     = 1'b1;

        case (state_reg)
            S_IDLE: begin
                if (q_stat.valid && out_free) begin
                    q_pop = 1'b1;
                    case (q_req.cmd)
                        CMD_PUSH_FRONT: begin
                            emit = 1'b1;
                            if (full) begin
                                e_stat = STAT_OVERFLOW;
                            end else begin
                                wr_en      = 1'b1;
                                wr_addr    = IDX_W'(front_reg);
                                front_next = front_reg + CNT_W'(1);
                            end
                        end
                        CMD_PUSH_BACK: begin
                            emit = 1'b1;
                            if (full) begin
                                e_stat = STAT_OVERFLOW;
                            end else begin
                                wr_en     = 1'b1;
                                wr_addr   = IDX_W'(cap_reg - back_inc);
                                back_next = back_inc;
                            end
                        end
                        CMD_POP_FRONT: begin
                            if (front_reg == '0) begin
                                emit   = 1'b1;
                                e_stat = STAT_UNDERFLOW;
                            end else begin
                                rd_en      = 1'b1;
                                rd_addr    = IDX_W'(front_reg - CNT_W'(1));
                                front_next = front_reg - CNT_W'(1);
                                state_next = S_POP;
                            end
                        end
                        CMD_POP_BACK: begin
                            if (back_reg == '0) begin
                                emit   = 1'b1;
                                e_stat = STAT_UNDERFLOW;
                            end else begin
                                rd_en      = 1'b1;
                                rd_addr    = IDX_W'(cap_reg - back_reg);
                                back_next  = back_reg - CNT_W'(1);
                                state_next = S_POP;
                            end
                        end
                        CMD_SEARCH: begin
                            key_next = WORD_WIDTH'(q_req.value);
                            if (front_reg != '0) begin
                                pos_next   = '0;
                                rem_next   = front_reg;
                                side_next  = 1'b0;
                                state_next = S_SRD;
                            end else if (back_reg != '0) begin
                                pos_next   = IDX_W'(cap_reg - CNT_W'(1));
                                rem_next   = back_reg;
                                side_next  = 1'b1;
                                state_next = S_SRD;
                            end else begin
                                state_next = S_DONE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_POP: begin
                if (out_free) begin
                    emit       = 1'b1;
                    e_data     = DATA_W'(rd_data_reg);
                    state_next = S_IDLE;
                end
            end
            S_SRD: begin
                rd_en      = 1'b1;
                rd_addr    = pos_reg;
                state_next = S_SCMP;
            end
            S_SCMP: begin
                if (!hit || out_free) begin
                    if (hit) begin
                        emit   = 1'b1;
                        e_stat = STAT_MATCH;
                        e_data = DATA_W'(rd_data_reg);
                        e_pos  = POS_W'(pos_reg);
                        e_last = 1'b0;
                    end
                    if (rem_reg == CNT_W'(1)) begin
                        if (!side_reg && back_reg != '0) begin
                            side_next  = 1'b1;
                            pos_next   = IDX_W'(cap_reg - CNT_W'(1));
                            rem_next   = back_reg;
                            state_next = S_SRD;
                        end else begin
                            state_next = S_DONE;
                        end
                    end else begin
                        rem_next   = rem_reg - CNT_W'(1);
                        pos_next   = side_reg ? pos_reg - IDX_W'(1) : pos_reg + IDX_W'(1);
                        state_next = S_SRD;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    emit       = 1'b1;
                    e_stat     = STAT_DONE;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_valid) begin
            if (cfg_data == '0) begin
                cap_next = CNT_W'(1);
            end else if (int'(cfg_data) > DEPTH) begin
                cap_next = CNT_W'(DEPTH);
            end else begin
                cap_next = CNT_W'(cfg_data);
            end
            front_next = '0;
            back_next  = '0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_stat_next  = m_stat_reg;
        m_data_next  = m_data_reg;
        m_pos_next   = m_pos_reg;
        m_last_next  = m_last_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_stat_next  = e_stat;
            m_data_next  = e_data;
            m_pos_next   = e_pos;
            m_last_next  = e_last;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cap_reg     <= CNT_W'(CAP_RST);
            front_reg   <= '0;
            back_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cap_reg     <= cap_next;
            front_reg   <= front_next;
            back_reg    <= back_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg    <= rem_next;
        pos_reg    <= pos_next;
        side_reg   <= side_next;
        key_reg    <= key_next;
        m_stat_reg <= m_stat_next;
        m_data_reg <= m_data_next;
        m_pos_reg  <= m_pos_next;
        m_last_reg <= m_last_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

[rtl/shared_array_double_stack_core.sv]
// Top level of the two-stacks-in-one-store block.
// Joins front end, request queue and execution unit. Depends on sda_pkg,
// sda_front, sda_queue and sda_back.
//
//  channel   direction  handshake                     payload
//  s_axis    in         s_axis_tvalid/s_axis_tready   tuser command, tdata value
//  m_axis    out        m_axis_tvalid/m_axis_tready   tuser status, tdata data+position,
//                                                     tlast last
//  cfg       in         cfg_valid/cfg_ready           cfg_data capacity
//
// Push, failed push and failed pop: result emitted from S_IDLE in the execution unit.
// Pop: S_IDLE starts the registered read of the entry store; S_POP emits the result.
// Search: one store read (S_SRD) and one compare (S_SCMP) per live entry, then S_DONE.
// Reset (aresetn low, synchronous) empties both stacks and sets capacity to min(DEPTH, 16).
// A two-entry queue accepts input while the execution unit or output stalls, until full.
module shared_array_double_stack_core import sda_pkg::*; #(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int WORD_WIDTH = WORD_W_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [VAL_W-1:0]        s_axis_tdata,   // value[31:0]
    input  logic [CMD_W-1:0]        s_axis_tuser,   // command[2:0]
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [OUT_TDATA_W-1:0]  m_axis_tdata,   // data[31:0], position[35:32], zero pad
    output logic [STAT_W-1:0]       m_axis_tuser,   // status[2:0]
    output logic                    m_axis_tlast,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CAP_W-1:0]        cfg_data
);

    sda_qstat_t q_stat;
    sda_req_t   push_req, pop_req;
    logic       q_push, q_pop;

    sda_front u_front (
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_full        (q_stat.full),
        .q_push        (q_push),
        .q_req         (push_req)
    );

    sda_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_req (push_req),
        .pop      (q_pop),
        .pop_req  (pop_req),
        .stat     (q_stat)
    );

    sda_back #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_stat        (q_stat),
        .q_req         (pop_req),
        .q_pop         (q_pop),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for shared_array_double_stack_core: two stacks in one store.
// Drives push, pop, search and unknown commands and capacity writes with random idling;
// compares every result with a mirror of the stacks. Depends on sda_pkg and RTL in rtl/.
module testbench;
    import sda_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = 3'd5;
    localparam logic [CMD_W-1:0] CMD_LAST_UNUSED  = 3'd7;
    localparam int SETTLE_CYCLES = 2 * DEPTH_DEF + 16;
    localparam int CYCLE_LIMIT   = 1_500_000;

    typedef struct {
        logic [STAT_W-1:0] status;
        logic [DATA_W-1:0] data;
        logic [POS_W-1:0]  position;
        logic              last;
    } stack_result_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [VAL_W-1:0]       s_axis_tdata;
    logic [CMD_W-1:0]       s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [STAT_W-1:0]      m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CAP_W-1:0]       cfg_data;

    stack_result_t    pending_results[$];
    logic [VAL_W-1:0] mirror_store[DEPTH_DEF];
    int               mirror_front;
    int               mirror_back;
    int               mirror_capacity;
    logic [VAL_W-1:0] key_pool[4];
    int               failures    = 0;
    int               cycle_count = 0;
    int               rx_hold     = 0;
    bit               tx_gaps_on  = 1'b1;
    bit               rx_stalls_on = 1'b1;

    shared_array_double_stack_core DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 30);
        return $urandom_range(0, 3);
    endfunction

    function automatic void push_result(input logic [STAT_W-1:0] status,
                                        input logic [DATA_W-1:0] data,
                                        input logic [POS_W-1:0] position,
                                        input logic last);
        stack_result_t r;
        r.status   = status;
        r.data     = data;
        r.position = position;
        r.last     = last;
        pending_results.insert(pending_results.size(), r);
    endfunction

    task automatic apply_stack_command(input logic [CMD_W-1:0] cmd,
                                       input logic [VAL_W-1:0] val);
        int idx;
        case (cmd)
            CMD_PUSH_FRONT: begin
                if (mirror_front + mirror_back >= mirror_capacity) begin
                    push_result(STAT_OVERFLOW, '0, '0, 1'b1);
                end else begin
                    mirror_store[mirror_front] = val;
                    mirror_front++;
                    push_result(STAT_OK, '0, '0, 1'b1);
                end
            end
            CMD_PUSH_BACK: begin
                if (mirror_front + mirror_back >= mirror_capacity) begin
                    push_result(STAT_OVERFLOW, '0, '0, 1'b1);
                end else begin
                    mirror_back++;
                    mirror_store[mirror_capacity - mirror_back] = val;
                    push_result(STAT_OK, '0, '0, 1'b1);
                end
            end
            CMD_POP_FRONT: begin
                if (mirror_front == 0) begin
                    push_result(STAT_UNDERFLOW, '0, '0, 1'b1);
                end else begin
                    mirror_front--;
                    push_result(STAT_OK, mirror_store[mirror_front], '0, 1'b1);
                end
            end
            CMD_POP_BACK: begin
                if (mirror_back == 0) begin
                    push_result(STAT_UNDERFLOW, '0, '0, 1'b1);
                end else begin
                    push_result(STAT_OK, mirror_store[mirror_capacity - mirror_back], '0, 1'b1);
                    mirror_back--;
                end
            end
            CMD_SEARCH: begin
                for (idx = 0; idx < mirror_front; idx++)
                    if (mirror_store[idx] == val)
                        push_result(STAT_MATCH, mirror_store[idx], POS_W'(idx), 1'b0);
                for (idx = mirror_capacity - 1; idx >= mirror_capacity - mirror_back; idx--)
                    if (mirror_store[idx] == val)
                        push_result(STAT_MATCH, mirror_store[idx], POS_W'(idx), 1'b0);
                push_result(STAT_DONE, '0, '0, 1'b1);
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [DATA_W-1:0] exp_v,
                               input logic [DATA_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            failures++;
        end
    endtask

    always @(posedge aclk) begin
        stack_result_t r;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual status %0d data %h",
                         $time, m_axis_tuser, m_axis_tdata[31:0]);
                failures++;
            end else begin
                r = pending_results[0];
                pending_results.delete(0);
                check_field("status", DATA_W'(r.status), DATA_W'(m_axis_tuser));
                check_field("data", r.data, m_axis_tdata[31:0]);
                check_field("position", DATA_W'(r.position), DATA_W'(m_axis_tdata[35:32]));
                check_field("last", DATA_W'(r.last), DATA_W'(m_axis_tlast));
            end
        end
    end

    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold > 0) begin
                m_axis_tready <= 1'b0;
                rx_hold--;
            end else begin
                m_axis_tready <= 1'b1;
                if (rx_stalls_on && $urandom_range(0, 4) == 0)
                    rx_hold = pick_gap();
            end
        end
    end

    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] val);
        int gap;
        gap = tx_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= val;
        s_axis_tuser  <= cmd;
        do @(posedge aclk); while (!s_axis_tready);
        apply_stack_command(cmd, val);
    endtask

    task automatic wait_idle(input int settle);
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        wait_idle(SETTLE_CYCLES);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        mirror_capacity = (value == 0) ? 1 : (value > DEPTH_DEF) ? DEPTH_DEF : value;
        mirror_front = 0;
        mirror_back  = 0;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [CMD_W-1:0] pick_command(input int push_pct, input int pop_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < push_pct / 2)
            return CMD_PUSH_FRONT;
        if (r < push_pct)
            return CMD_PUSH_BACK;
        if (r < push_pct + pop_pct / 2)
            return CMD_POP_FRONT;
        if (r < push_pct + pop_pct)
            return CMD_POP_BACK;
        if (r < 95)
            return CMD_SEARCH;
        return CMD_W'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED));
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        if ($urandom_range(0, 9) < 7)
            return key_pool[$urandom_range(0, 3)];
        return $urandom();
    endfunction

    task automatic run_random_phase(input logic [CAP_W-1:0] cap, input int items,
                                    input int push_pct, input int pop_pct,
                                    input bit idling, input bit drain_pause);
        int done_items;
        logic [CMD_W-1:0] cmd;
        write_capacity(cap);
        tx_gaps_on   = idling;
        rx_stalls_on = idling;
        key_pool[0] = $urandom();
        key_pool[1] = $urandom();
        key_pool[2] = $urandom_range(0, 1) ? '1 : '0;
        key_pool[3] = $urandom_range(0, 15);
        done_items = 0;
        while (done_items < items) begin
            if (drain_pause && done_items == items / 2)
                wait_idle(0);
            cmd = pick_command(push_pct, pop_pct);
            send_command(cmd, pick_value());
            if (cmd < CMD_FIRST_UNUSED)
                done_items++;
        end
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
    endtask

    task automatic test_empty_stacks();
        send_command(CMD_POP_FRONT, $urandom());
        send_command(CMD_POP_BACK, $urandom());
        send_command(CMD_SEARCH, '0);
    endtask

    task automatic test_push_pop_extremes();
        send_command(CMD_PUSH_FRONT, '0);
        send_command(CMD_PUSH_FRONT, '1);
        send_command(CMD_PUSH_BACK, '1);
        send_command(CMD_PUSH_BACK, '0);
        send_command(CMD_SEARCH, '1);
        send_command(CMD_SEARCH, '0);
        send_command(CMD_POP_FRONT, $urandom());
        send_command(CMD_POP_BACK, $urandom());
        send_command(CMD_POP_FRONT, $urandom());
        send_command(CMD_POP_BACK, $urandom());
    endtask

    task automatic test_unknown_commands();
        int c;
        for (c = CMD_FIRST_UNUSED; c <= CMD_LAST_UNUSED; c++)
            send_command(CMD_W'(c), $urandom());
        send_command(CMD_SEARCH, $urandom());
    endtask

    task automatic test_capacity_limits();
        write_capacity(5'd1);
        send_command(CMD_PUSH_BACK, 32'h1234_5678);
        send_command(CMD_PUSH_FRONT, 32'hDEAD_BEEF);
        send_command(CMD_SEARCH, 32'h1234_5678);
        send_command(CMD_POP_FRONT, '0);
        send_command(CMD_POP_BACK, '0);
        write_capacity(5'd0);
        send_command(CMD_PUSH_FRONT, 32'hCAFE_F00D);
        send_command(CMD_PUSH_BACK, 32'h0BAD_0BAD);
        send_command(CMD_POP_FRONT, '0);
        write_capacity(5'd31);
    endtask

    initial begin
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_PUSH_FRONT;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        mirror_capacity = CAP_RST_DEF;
        mirror_front    = 0;
        mirror_back     = 0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_stacks();
        test_push_pop_extremes();
        test_unknown_commands();
        test_capacity_limits();
        run_random_phase(5'd16, 70, 70, 15, 1'b1, 1'b0);
        run_random_phase(5'd2, 50, 40, 40, 1'b1, 1'b0);
        run_random_phase(5'd17, 50, 50, 30, 1'b0, 1'b0);
        run_random_phase(CAP_W'($urandom_range(1, 16)), 50, 45, 35, 1'b1, 1'b1);
        run_random_phase(CAP_W'($urandom()), 60, 50, 30, 1'b1, 1'b0);

        wait_idle(SETTLE_CYCLES);
        if (failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[files.f]
rtl/sda_pkg.sv
rtl/sda_front.sv
rtl/sda_queue.sv
rtl/sda_back.sv
rtl/shared_array_double_stack_core.sv
tb/sv/testbench.sv
